[hw/rtl/multichannel_input_debouncer_assert.svh]
// ----------------------------------------------------------------------------
// Debouncer assertion macros
// Shared property wrappers for the debouncer checks.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_INPUT_DEBOUNCER_ASSERT_SVH
`define MULTICHANNEL_INPUT_DEBOUNCER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define MIDEB_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("debouncer check failed");

// Check that the consequent holds in the cycle after the antecedent
`define MIDEB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("debouncer check failed");

`endif

[hw/rtl/mideb_pkg.sv]
// ----------------------------------------------------------------------------
// Debouncer package
// Channel geometry, register codes and reset values.
// ----------------------------------------------------------------------------
package mideb_pkg;

    localparam int CHANNELS   = 11;
    localparam int COUNT_BITS = 5;
    localparam int CH_IDX_W   = 4;
    localparam int EVENT_W    = 8;
    localparam int PHASE_W    = 4;
    localparam int GROUP_BITS = 2;
    localparam int THR_W      = CHANNELS * COUNT_BITS;
    localparam int GRP_W      = CHANNELS * GROUP_BITS;
    localparam int CFG_DATA_W = THR_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(9);
    localparam logic [PHASE_W-1:0] PHASE_TENTH = PHASE_W'(1);

    localparam logic [CHANNELS-1:0] ACTIVE_LOW_RST = CHANNELS'(2031);
    localparam logic [THR_W-1:0]    VALID_THR_RST  = THR_W'(64'd18595048167968900);
    localparam logic [THR_W-1:0]    INVALID_THR_RST = THR_W'(64'd6973210463703172);
    localparam logic [GRP_W-1:0]    SCAN_GROUPS_RST = GRP_W'(22698);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LOW  = 2'd0,
        CFG_VALID_THR   = 2'd1,
        CFG_INVALID_THR = 2'd2,
        CFG_SCAN_GROUPS = 2'd3
    } cfg_reg_t;

    typedef enum logic [GROUP_BITS-1:0] {
        GRP_EVERY = 2'd0,
        GRP_ODD   = 2'd1,
        GRP_TENTH = 2'd2,
        GRP_OFF   = 2'd3
    } scan_group_t;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [EVENT_W-1:0]    event_t;

endpackage

[hw/rtl/mideb_if.sv]
// ----------------------------------------------------------------------------
// Debouncer channel interfaces
// Tick input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface mideb_in_if;
    logic                               valid;
    logic                               ready;
    logic [mideb_pkg::CHANNELS-1:0]     pin_levels;
    logic                               clear_counts;
    logic [mideb_pkg::CH_IDX_W-1:0]     read_channel;

    modport source (output valid, output pin_levels, output clear_counts,
                    output read_channel, input ready);
    modport sink   (input valid, input pin_levels, input clear_counts,
                    input read_channel, output ready);
endinterface

interface mideb_out_if;
    logic                               valid;
    logic                               ready;
    logic [mideb_pkg::CHANNELS-1:0]     debounced_state;
    logic [mideb_pkg::CHANNELS-1:0]     became_valid;
    logic [mideb_pkg::CHANNELS-1:0]     became_invalid;
    logic [mideb_pkg::EVENT_W-1:0]      valid_event_count;
    logic [mideb_pkg::EVENT_W-1:0]      invalid_event_count;

    modport source (output valid, output debounced_state, output became_valid,
                    output became_invalid, output valid_event_count,
                    output invalid_event_count, input ready);
    modport sink   (input valid, input debounced_state, input became_valid,
                    input became_invalid, input valid_event_count,
                    input invalid_event_count, output ready);
endinterface

interface mideb_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mideb_pkg::CFG_IDX_W-1:0]    index;
    logic [mideb_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/multichannel_input_debouncer.sv]
// ----------------------------------------------------------------------------
// Multichannel input debouncer
// A tick beat's result is registered and presented in the next cycle.
// Throughput: one tick per cycle; the single result register is refilled in
// the same cycle it drains, so input ready only drops while a result stalls.
// Reset: rst_n clears state, counters, event counts, tick phase and restores
// the register defaults; no clearing pass, ticks are taken right away.
// ----------------------------------------------------------------------------
module multichannel_input_debouncer (
    input  logic         clk,
    input  logic         rst_n,
    mideb_in_if.sink     samples,
    mideb_out_if.source  results,
    mideb_cfg_if.sink    cfg
);
    import mideb_pkg::*;

    // Configuration registers
    logic [CHANNELS-1:0] active_low_reg;
    logic [THR_W-1:0]    valid_thr_reg;
    logic [THR_W-1:0]    invalid_thr_reg;
    logic [GRP_W-1:0]    scan_groups_reg;

    // Debounce state
    logic [CHANNELS-1:0] state_reg, state_next;
    count_t              counter_reg [CHANNELS];
    count_t              counter_next [CHANNELS];
    event_t              valid_ev_reg [CHANNELS];
    event_t              valid_ev_next [CHANNELS];
    event_t              invalid_ev_reg [CHANNELS];
    event_t              invalid_ev_next [CHANNELS];
    logic [PHASE_W-1:0]  phase_reg, phase_next;

    // Result stage
    logic                out_valid_reg;
    logic [CHANNELS-1:0] rise_next, fall_next;
    logic [CHANNELS-1:0] rise_reg, fall_reg, dstate_reg;
    event_t              vcount_next, icount_next;
    event_t              vcount_reg, icount_reg;

    logic in_fire;
    logic cfg_fire;

    assign samples.ready = !out_valid_reg || results.ready;
    assign in_fire       = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;
    assign cfg_fire      = cfg.valid;

    // Advance the tick phase modulo ten
    always_comb
    begin
        phase_next = (phase_reg >= PHASE_LAST) ? '0 : phase_reg + 1'b1;
    end

    // Per-channel sample, compare and count
    always_comb
    begin
        scan_group_t               grp;
        logic                      sampled;
        logic                      lvl_valid;
        count_t                    thr;
        logic [COUNT_BITS:0]       cnt_inc;
        event_t                    v_base;
        event_t                    i_base;

        state_next = state_reg;
        rise_next  = '0;
        fall_next  = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            grp = scan_group_t'(scan_groups_reg[GROUP_BITS*i +: GROUP_BITS]);
            case (grp)
                GRP_EVERY: sampled = 1'b1;
                GRP_ODD:   sampled = phase_next[0];
                GRP_TENTH: sampled = (phase_next == PHASE_TENTH);
                GRP_OFF:   sampled = 1'b0;
                default:   sampled = 1'b0;
            endcase

            lvl_valid = samples.pin_levels[i] ^ active_low_reg[i];
            thr = lvl_valid ? valid_thr_reg[COUNT_BITS*i +: COUNT_BITS]
                            : invalid_thr_reg[COUNT_BITS*i +: COUNT_BITS];
            if (thr == '0)
            begin
                thr = count_t'(1);
            end
            cnt_inc = {1'b0, counter_reg[i]} + 1'b1;

            counter_next[i] = counter_reg[i];
            if (sampled)
            begin
                if (lvl_valid == state_reg[i])
                begin
                    counter_next[i] = '0;
                end
                else if (cnt_inc >= {1'b0, thr})
                begin
                    counter_next[i] = '0;
                    state_next[i]   = lvl_valid;
                    rise_next[i]    = lvl_valid;
                    fall_next[i]    = !lvl_valid;
                end
                else
                begin
                    counter_next[i] = cnt_inc[COUNT_BITS-1:0];
                end
            end

            // Drop event counts on request, then add this tick's edges
            v_base = samples.clear_counts ? '0 : valid_ev_reg[i];
            i_base = samples.clear_counts ? '0 : invalid_ev_reg[i];
            valid_ev_next[i]   = v_base + event_t'(rise_next[i]);
            invalid_ev_next[i] = i_base + event_t'(fall_next[i]);
        end
    end

    // Select the reported channel's counts
    always_comb
    begin
        vcount_next = '0;
        icount_next = '0;
        if (samples.read_channel < CH_IDX_W'(CHANNELS))
        begin
            vcount_next = valid_ev_next[samples.read_channel];
            icount_next = invalid_ev_next[samples.read_channel];
        end
    end

    // Hold configuration and debounce state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg  <= ACTIVE_LOW_RST;
            valid_thr_reg   <= VALID_THR_RST;
            invalid_thr_reg <= INVALID_THR_RST;
            scan_groups_reg <= SCAN_GROUPS_RST;
            state_reg       <= '0;
            phase_reg       <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                counter_reg[i]    <= '0;
                valid_ev_reg[i]   <= '0;
                invalid_ev_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_reg_t'(cfg.index))
                    CFG_ACTIVE_LOW:  active_low_reg  <= cfg.data[CHANNELS-1:0];
                    CFG_VALID_THR:   valid_thr_reg   <= cfg.data[THR_W-1:0];
                    CFG_INVALID_THR: invalid_thr_reg <= cfg.data[THR_W-1:0];
                    CFG_SCAN_GROUPS: scan_groups_reg <= cfg.data[GRP_W-1:0];
                    default:         ;
                endcase
            end
            if (in_fire)
            begin
                state_reg <= state_next;
                phase_reg <= phase_next;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    counter_reg[i]    <= counter_next[i];
                    valid_ev_reg[i]   <= valid_ev_next[i];
                    invalid_ev_reg[i] <= invalid_ev_next[i];
                end
            end
        end
    end

    // Track the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dstate_reg <= state_next;
            rise_reg   <= rise_next;
            fall_reg   <= fall_next;
            vcount_reg <= vcount_next;
            icount_reg <= icount_next;
        end
    end

    assign results.valid               = out_valid_reg;
    assign results.debounced_state     = dstate_reg;
    assign results.became_valid        = rise_reg;
    assign results.became_invalid      = fall_reg;
    assign results.valid_event_count   = vcount_reg;
    assign results.invalid_event_count = icount_reg;

endmodule

[hw/rtl/mideb_checker.sv]
// ----------------------------------------------------------------------------
// Debouncer port checker
// Watches the tick and result channels of the debouncer top level.
// ----------------------------------------------------------------------------
`include "multichannel_input_debouncer_assert.svh"

module mideb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           tick_valid,
    input logic                           tick_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [mideb_pkg::CHANNELS-1:0] debounced_state,
    input logic [mideb_pkg::CHANNELS-1:0] became_valid,
    input logic [mideb_pkg::CHANNELS-1:0] became_invalid
);
    import mideb_pkg::*;

    // A stalled result beat holds its payload
    `MIDEB_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(debounced_state) && $stable(became_valid) && $stable(became_invalid))

    // An accepted tick always yields a result on the next cycle
    `MIDEB_ASSERT_NEXT(a_tick_result, clk, rst_n, tick_valid && tick_ready, out_valid)

    // A channel cannot turn both ways in one tick
    `MIDEB_ASSERT_SAME(a_edge_excl, clk, rst_n, out_valid, (became_valid & became_invalid) == '0)

    // Edge flags agree with the reported state
    `MIDEB_ASSERT_SAME(a_edge_state, clk, rst_n, out_valid, ((became_valid & ~debounced_state) == '0) && ((became_invalid & debounced_state) == '0))

endmodule

bind multichannel_input_debouncer mideb_checker u_mideb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .tick_valid      (samples.valid),
    .tick_ready      (samples.ready),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .debounced_state (results.debounced_state),
    .became_valid    (results.became_valid),
    .became_invalid  (results.became_invalid)
);
